>>> hw/rtl/calendar_clock_tick_core_defines.svh
// Assertion macros for the checker file.
`ifndef CALENDAR_CLOCK_TICK_CORE_DEFINES_SVH
`define CALENDAR_CLOCK_TICK_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CCT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("calendar clock check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CCT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("calendar clock check failed");

`endif

>>> hw/rtl/cct_pkg.sv
`default_nettype none

package cct_pkg;

  localparam int unsigned YearTopDefault = 9999;

  localparam logic [5:0]  SecLast   = 6'd59;
  localparam logic [5:0]  MinLast   = 6'd59;
  localparam logic [4:0]  HourLast  = 5'd23;
  localparam logic [3:0]  MonthLast = 4'd12;
  localparam logic [4:0]  LeapFeb   = 5'd29;

  // y divisible by 25 <=> (y * inverse of 25 mod 2^14) <= floor((2^14-1)/25)
  localparam logic [13:0] Inv25     = 14'd7209;
  localparam logic [13:0] Div25Max  = 14'd655;

  // reset time and date
  localparam logic [4:0]  ResetDay   = 5'd1;
  localparam logic [3:0]  ResetMonth = 4'd1;
  localparam logic [13:0] ResetYear  = 14'd2000;

  typedef struct packed {
    logic        func;
    logic [5:0]  load_seconds;
    logic [5:0]  load_minutes;
    logic [4:0]  load_hours;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [13:0] load_year;
  } cct_in_t;

  typedef struct packed {
    logic [5:0]  now_seconds;
    logic [5:0]  now_minutes;
    logic [4:0]  now_hours;
    logic [4:0]  now_day;
    logic [3:0]  now_month;
    logic [13:0] now_year;
    logic        load_rejected;
  } cct_out_t;

  typedef struct packed {
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } cct_time_t;

  // Gregorian leap rule with constant-divisor checks only
  function automatic logic is_leap(input logic [13:0] y);
    logic [13:0] prod;
    logic        div4;
    logic        div16;
    logic        div25;
    prod  = y * Inv25;
    div4  = (y[1:0] == 2'd0);
    div16 = (y[3:0] == 4'd0);
    div25 = (prod <= Div25Max);
    return (div4 && !div25) || (div16 && div25);
  endfunction

  // Month length; zero for a month outside 1..12
  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? LeapFeb : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/calendar_clock_tick_core.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o  | in_item_i  (cct_in_t)
// out     | output    | out_valid_o / out_stall_i| out_item_o (cct_out_t)
//
// One item per cycle sustained while no result is held; a taken item passes the input register,
// then the state update and result register.
// The clock state update is a single pass of the step logic; a new item enters each cycle unless stalled.
// Reset clears both valid flags and sets the clock to 00:00:00, day 1, month 1, year 2000.
// A stalled result holds in the result register; the input register keeps taking items
// until it is full and the result cannot move.
`default_nettype none

module calendar_clock_tick_core import cct_pkg::*; #(
  parameter int unsigned YEAR_TOP = YearTopDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  cct_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cct_out_t out_item_o
);

  logic      in_valid_q;
  cct_in_t   in_item_q;
  cct_time_t time_q;
  cct_time_t time_d;
  logic      rejected;
  logic      out_valid_q;
  cct_out_t  out_item_q;
  logic      advance;

  // input register moves into the result stage unless the result is held
  assign advance    = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  cct_step #(
    .YEAR_TOP(YEAR_TOP)
  ) u_step (
    .cur_i     (time_q),
    .item_i    (in_item_q),
    .nxt_o     (time_d),
    .rejected_o(rejected)
  );

  // clock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= {6'd0, 6'd0, 5'd0, ResetDay, ResetMonth, ResetYear};
    end else if (advance) begin
      time_q <= time_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // time fields in result order, then the reject flag
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= {time_d, rejected};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

>>> hw/rtl/cct_step.sv
`default_nettype none

// Next time and date for one item: a one-second tick or a checked load.
module cct_step import cct_pkg::*; #(
  parameter int unsigned YEAR_TOP = YearTopDefault
) (
  input  cct_time_t cur_i,
  input  cct_in_t   item_i,
  output cct_time_t nxt_o,
  output logic      rejected_o
);

  localparam logic [13:0] YearTop = 14'(YEAR_TOP);

  cct_time_t  tick_t;
  logic       sec_wrap;
  logic       min_wrap;
  logic       hour_wrap;
  logic [4:0] cur_dim;
  logic [4:0] load_dim;
  logic       load_ok;

  assign sec_wrap  = (cur_i.seconds >= SecLast);
  assign min_wrap  = (cur_i.minutes >= MinLast);
  assign hour_wrap = (cur_i.hours >= HourLast);
  assign cur_dim   = days_in(cur_i.month, is_leap(cur_i.year));
  assign load_dim  = days_in(item_i.load_month, is_leap(item_i.load_year));

  // tick: ripple carry through seconds, minutes, hours and the date
  always_comb begin
    tick_t = cur_i;
    if (!sec_wrap) begin
      tick_t.seconds = cur_i.seconds + 6'd1;
    end else begin
      tick_t.seconds = '0;
      if (!min_wrap) begin
        tick_t.minutes = cur_i.minutes + 6'd1;
      end else begin
        tick_t.minutes = '0;
        if (!hour_wrap) begin
          tick_t.hours = cur_i.hours + 5'd1;
        end else begin
          tick_t.hours = '0;
          if (cur_i.day < cur_dim) begin
            tick_t.day = cur_i.day + 5'd1;
          end else if (cur_i.month >= MonthLast || cur_i.month == 4'd0) begin
            tick_t.day   = 5'd1;
            tick_t.month = 4'd1;
            tick_t.year  = (cur_i.year >= YearTop) ? 14'd0 : cur_i.year + 14'd1;
          end else begin
            tick_t.day   = 5'd1;
            tick_t.month = cur_i.month + 4'd1;
          end
        end
      end
    end
  end

  // load: every field in range, day within the loaded month
  assign load_ok = (item_i.load_seconds <= SecLast) && (item_i.load_minutes <= MinLast) &&
                   (item_i.load_hours <= HourLast) && (item_i.load_year <= YearTop) &&
                   (item_i.load_day != 5'd0) && (item_i.load_day <= load_dim);

  always_comb begin
    rejected_o = 1'b0;
    nxt_o      = cur_i;
    if (!item_i.func) begin
      nxt_o = tick_t;
    end else if (load_ok) begin
      nxt_o.seconds = item_i.load_seconds;
      nxt_o.minutes = item_i.load_minutes;
      nxt_o.hours   = item_i.load_hours;
      nxt_o.day     = item_i.load_day;
      nxt_o.month   = item_i.load_month;
      nxt_o.year    = item_i.load_year;
    end else begin
      rejected_o = 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cct_checker.sv
`default_nettype none
`include "calendar_clock_tick_core_defines.svh"

// Port-level checks on the calendar clock core.
module cct_checker import cct_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input cct_in_t  in_item_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input cct_out_t out_item_o
);

  logic in_take;
  logic in_seen;

  assign in_take = in_valid_i && !in_stall_o;
  assign in_seen = in_take && (in_item_i.func || !in_item_i.func);

  // a held result stays put
  `CCT_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
                  out_valid_o && $stable(out_item_o))

  // time of day always in range
  `CCT_ASSERT_IMP(a_time_range, out_valid_o,
                  out_item_o.now_seconds <= SecLast && out_item_o.now_minutes <= MinLast &&
                  out_item_o.now_hours <= HourLast)

  // date fields always in range
  `CCT_ASSERT_IMP(a_date_range, out_valid_o,
                  out_item_o.now_day != 5'd0 && out_item_o.now_month != 4'd0 &&
                  out_item_o.now_month <= MonthLast)

  // a taken item reaches the output through the input and result registers if the output is not held
  `CCT_ASSERT_NXT(a_latency, in_seen ##1 !out_stall_i, out_valid_o)

endmodule

bind calendar_clock_tick_core cct_checker u_cct_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);

`default_nettype wire

>>> tb/sv/calendar_clock_tick_core_test.sv
module calendar_clock_tick_core_test;
  import cct_pkg::*;

  localparam int unsigned YearTop        = YearTopDefault;
  localparam logic        FuncTick       = 1'b0;
  localparam logic        FuncLoad       = 1'b1;
  localparam int unsigned RandItems      = 900;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned LongHoldAt     = 300;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned DrainCycles    = 10;
  localparam int unsigned ReportMax      = 10;

  // tick items, one with every load bit set (those bits are ignored)
  localparam cct_in_t TickOnes = {FuncTick, 40'hFF_FFFF_FFFF};
  localparam cct_in_t TickZero = '0;

  typedef struct {
    cct_in_t  item;
    bit       typed;
    cct_out_t want;
  } calendar_case_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  cct_in_t  in_item_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  cct_out_t out_item_o;

  cct_time_t      cal_now;
  cct_out_t       pending_now[$];
  calendar_case_t calendar_cases[$];
  int unsigned    fail_cnt       = 0;
  int unsigned    items_sent     = 0;
  int unsigned    cycle_cnt      = 0;
  bit             no_idle        = 1'b0;
  bit             long_hold_done = 1'b0;

  calendar_clock_tick_core #(
    .YEAR_TOP(YearTop)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #2 clk_i = ~clk_i;

  // Gregorian calendar arithmetic
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_len(input int unsigned m, input int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Apply one item to the calendar and return the time shown after it
  function automatic cct_out_t step_calendar(input cct_in_t it);
    int unsigned s, mi, h, d, mo, y;
    cct_out_t    r;
    s  = cal_now.seconds;
    mi = cal_now.minutes;
    h  = cal_now.hours;
    d  = cal_now.day;
    mo = cal_now.month;
    y  = cal_now.year;
    r  = '0;
    if (it.func == FuncTick) begin
      s++;
      if (s >= 60) begin
        s = 0;
        mi++;
        if (mi >= 60) begin
          mi = 0;
          h++;
          if (h >= 24) begin
            h = 0;
            if (d < month_len(mo, y)) begin
              d++;
            end else if (mo >= 12 || mo < 1) begin
              d  = 1;
              mo = 1;
              y  = (y >= YearTop) ? 0 : y + 1;
            end else begin
              d = 1;
              mo++;
            end
          end
        end
      end
    end else if (it.load_seconds < 60 && it.load_minutes < 60 && it.load_hours < 24 &&
                 it.load_month >= 1 && it.load_month <= 12 && it.load_year <= YearTop &&
                 it.load_day >= 1 &&
                 it.load_day <= month_len(it.load_month, it.load_year)) begin
      s  = it.load_seconds;
      mi = it.load_minutes;
      h  = it.load_hours;
      d  = it.load_day;
      mo = it.load_month;
      y  = it.load_year;
    end else begin
      r.load_rejected = 1'b1;
    end
    cal_now.seconds = 6'(s);
    cal_now.minutes = 6'(mi);
    cal_now.hours   = 5'(h);
    cal_now.day     = 5'(d);
    cal_now.month   = 4'(mo);
    cal_now.year    = 14'(y);
    r.now_seconds   = cal_now.seconds;
    r.now_minutes   = cal_now.minutes;
    r.now_hours     = cal_now.hours;
    r.now_day       = cal_now.day;
    r.now_month     = cal_now.month;
    r.now_year      = cal_now.year;
    return r;
  endfunction

  function automatic cct_in_t mk_load(input int unsigned s, mi, h, d, mo, y);
    cct_in_t it;
    it              = '0;
    it.func         = FuncLoad;
    it.load_seconds = 6'(s);
    it.load_minutes = 6'(mi);
    it.load_hours   = 5'(h);
    it.load_day     = 5'(d);
    it.load_month   = 4'(mo);
    it.load_year    = 14'(y);
    return it;
  endfunction

  function automatic cct_out_t mk_now(input int unsigned s, mi, h, d, mo, y,
                                      input bit rej);
    cct_out_t r;
    r.now_seconds   = 6'(s);
    r.now_minutes   = 6'(mi);
    r.now_hours     = 5'(h);
    r.now_day       = 5'(d);
    r.now_month     = 4'(mo);
    r.now_year      = 14'(y);
    r.load_rejected = rej;
    return r;
  endfunction

  function automatic string fmt_now(input cct_out_t r);
    return $sformatf("%02d:%02d:%02d %0d-%0d-%0d rej=%0b", r.now_hours, r.now_minutes,
                     r.now_seconds, r.now_year, r.now_month, r.now_day, r.load_rejected);
  endfunction

  // Random item with the given func and every load field bit random
  function automatic cct_in_t random_item(input logic f);
    logic [63:0] raw;
    cct_in_t     it;
    raw     = {$urandom(), $urandom()};
    it      = raw[$bits(cct_in_t)-1:0];
    it.func = f;
    return it;
  endfunction

  // Valid load, mostly just short of a second/minute/hour/day/year rollover
  function automatic cct_in_t boundary_load();
    int unsigned mo, y, len;
    cct_in_t     it;
    mo = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 12);
    case ($urandom_range(0, 5))
      0:       y = YearTop;
      1:       y = 100 * $urandom_range(0, YearTop / 100);
      2:       y = 4 * $urandom_range(0, YearTop / 4);
      default: y = $urandom_range(0, YearTop);
    endcase
    len = month_len(mo, y);
    it  = mk_load(($urandom_range(0, 9) < 7) ? $urandom_range(48, 59) : $urandom_range(0, 59),
                  ($urandom_range(0, 9) < 6) ? 59 : $urandom_range(0, 59),
                  ($urandom_range(0, 9) < 6) ? 23 : $urandom_range(0, 23),
                  ($urandom_range(0, 9) < 6) ? len : $urandom_range(1, len),
                  mo, y);
    return it;
  endfunction

  // Load with exactly one field out of range
  function automatic cct_in_t broken_load();
    int unsigned len;
    cct_in_t     it;
    it  = boundary_load();
    len = month_len(it.load_month, it.load_year);
    case ($urandom_range(0, 6))
      0: it.load_seconds = 6'($urandom_range(60, 63));
      1: it.load_minutes = 6'($urandom_range(60, 63));
      2: it.load_hours   = 5'($urandom_range(24, 31));
      3: it.load_day     = 5'd0;
      4: it.load_day     = (len < 31) ? 5'($urandom_range(len + 1, 31)) : 5'd0;
      5: it.load_month   = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
      default: it.load_year = 14'($urandom_range(YearTop + 1, 16383));
    endcase
    return it;
  endfunction

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic void report_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= ReportMax) $display("%s", msg);
  endfunction

  function automatic void add_case(input cct_in_t it, input bit typed, input cct_out_t want);
    calendar_case_t c;
    c.item  = it;
    c.typed = typed;
    c.want  = want;
    calendar_cases.push_back(c);
  endfunction

  // Offer one item after a random gap; record the expected time once it is taken
  task automatic offer_item(input cct_in_t it, input bit typed, input cct_out_t want);
    int unsigned gap;
    cct_out_t    predicted;
    gap = idle_len();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = step_calendar(it);
    pending_now.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Compare one result with the oldest expected time
  task automatic check_now(input cct_out_t got);
    cct_out_t want;
    string    diffs;
    if (pending_now.size() == 0) begin
      report_failure($sformatf("result with no item pending: %s", fmt_now(got)));
      return;
    end
    want  = pending_now.pop_front();
    diffs = "";
    if (got.now_seconds !== want.now_seconds)     diffs = {diffs, " seconds"};
    if (got.now_minutes !== want.now_minutes)     diffs = {diffs, " minutes"};
    if (got.now_hours !== want.now_hours)         diffs = {diffs, " hours"};
    if (got.now_day !== want.now_day)             diffs = {diffs, " day"};
    if (got.now_month !== want.now_month)         diffs = {diffs, " month"};
    if (got.now_year !== want.now_year)           diffs = {diffs, " year"};
    if (got.load_rejected !== want.load_rejected) diffs = {diffs, " load_rejected"};
    if (diffs != "") begin
      report_failure($sformatf("mismatch in%s: expected %s, got %s", diffs, fmt_now(want),
                               fmt_now(got)));
    end
  endtask

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_now(out_item_o);
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up
  initial begin : result_side
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (!long_hold_done && items_sent >= LongHoldAt) begin
        long_hold_done = 1'b1;
        repeat (LongHoldCycles) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end else begin
        n = idle_len();
        repeat (n) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Run limit
  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main_seq
    int unsigned rand_cnt;
    int unsigned pick;
    int unsigned run;

    cal_now = {6'd0, 6'd0, 5'd0, ResetDay, ResetMonth, ResetYear};

    // Directed cases: extremes, leap days, rollovers, each kind of rejected load
    add_case(TickOnes, 1'b1, mk_now(1, 0, 0, 1, 1, 2000, 1'b0));
    add_case(mk_load(59, 59, 23, 31, 12, 9999), 1'b1, mk_now(59, 59, 23, 31, 12, 9999, 1'b0));
    add_case(TickZero, 1'b1, mk_now(0, 0, 0, 1, 1, 0, 1'b0));
    add_case(mk_load(59, 59, 23, 28, 2, 2000), 1'b1, mk_now(59, 59, 23, 28, 2, 2000, 1'b0));
    add_case(TickZero, 1'b1, mk_now(0, 0, 0, 29, 2, 2000, 1'b0));
    add_case(mk_load(15, 30, 12, 29, 2, 1900), 1'b1, mk_now(0, 0, 0, 29, 2, 2000, 1'b1));
    add_case(mk_load(59, 59, 23, 28, 2, 1900), 1'b1, mk_now(59, 59, 23, 28, 2, 1900, 1'b0));
    add_case(TickZero, 1'b1, mk_now(0, 0, 0, 1, 3, 1900, 1'b0));
    add_case(mk_load(8, 7, 6, 29, 2, 2004), 1'b1, mk_now(8, 7, 6, 29, 2, 2004, 1'b0));
    add_case(mk_load(8, 7, 6, 29, 2, 2100), 1'b0, '0);
    add_case(mk_load(59, 59, 23, 31, 1, 2023), 1'b1, mk_now(59, 59, 23, 31, 1, 2023, 1'b0));
    add_case(TickOnes, 1'b1, mk_now(0, 0, 0, 1, 2, 2023, 1'b0));
    add_case(mk_load(0, 0, 0, 31, 4, 2023), 1'b0, '0);
    add_case(mk_load(63, 0, 0, 1, 1, 2000), 1'b0, '0);
    add_case(mk_load(0, 60, 0, 1, 1, 2000), 1'b0, '0);
    add_case(mk_load(0, 0, 31, 1, 1, 2000), 1'b0, '0);
    add_case(mk_load(0, 0, 0, 0, 1, 2000), 1'b0, '0);
    add_case(mk_load(0, 0, 0, 1, 13, 2000), 1'b0, '0);
    add_case(mk_load(0, 0, 0, 1, 1, 10000), 1'b0, '0);
    add_case(mk_load(63, 63, 31, 31, 15, 16383), 1'b0, '0);
    add_case(mk_load(0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_case(TickZero, 1'b0, '0);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (calendar_cases[i]) begin
      offer_item(calendar_cases[i].item, calendar_cases[i].typed, calendar_cases[i].want);
    end

    // Random part: mostly a load near a rollover followed by ticks across it
    rand_cnt = 0;
    while (rand_cnt < RandItems) begin
      no_idle = (rand_cnt >= 500 && rand_cnt < 600);
      pick    = $urandom_range(0, 99);
      if (pick < 70) begin
        offer_item(boundary_load(), 1'b0, '0);
        rand_cnt++;
        run = $urandom_range(1, 14);
        repeat (run) begin
          offer_item(random_item(FuncTick), 1'b0, '0);
          rand_cnt++;
        end
      end else if (pick < 85) begin
        offer_item(broken_load(), 1'b0, '0);
        rand_cnt++;
      end else if (pick < 93) begin
        offer_item(random_item(FuncLoad), 1'b0, '0);
        rand_cnt++;
      end else begin
        run = $urandom_range(1, 30);
        repeat (run) begin
          offer_item(random_item(FuncTick), 1'b0, '0);
          rand_cnt++;
        end
      end
    end
    no_idle = 1'b0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then keep watching for stray results
    while (pending_now.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> calendar_clock_tick_core.f
+incdir+hw/rtl
hw/rtl/cct_pkg.sv
hw/rtl/cct_step.sv
hw/rtl/calendar_clock_tick_core.sv
hw/rtl/cct_checker.sv
tb/sv/calendar_clock_tick_core_test.sv
